// File: design/srcc_pkg.sv
// shared types, constants and calendar helpers for the seconds-to-calendar rtc
// used by srcc_ctrl, srcc_datapath and the top level seconds_rtc_calendar_convert
// no dependencies
package srcc_pkg;

  localparam int unsigned CountW    = 32;
  localparam int unsigned DaysW     = 16;
  localparam int unsigned KW        = 2;
  localparam int unsigned OutW      = 73;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned ProdW     = CountW + DaysW;

  localparam logic [CountW-1:0] CountAtReset = 32'd720895200;
  localparam logic [11:0]       FirstYear    = 12'd2000;
  localparam logic [DaysW-1:0]  WdayOffset   = 16'd5;

  // request kinds carried on the slave tuser
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TICK,
    OP_SET,
    OP_LOAD_DAY,
    OP_DIV_EST,
    OP_DIV_REM,
    OP_DIV_FIX,
    OP_LOAD_HOUR,
    OP_LOAD_MIN,
    OP_LOAD_WDAY,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_OUT_LOAD
  } dp_op_e;

  // divisor selection of the shared reciprocal divider
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } div_sel_e;

  // phase counter of one divide: estimate, remainder, correction
  localparam logic [KW-1:0] KDivEst = 2'd2;
  localparam logic [KW-1:0] KDivRem = 2'd1;
  localparam logic [KW-1:0] KDivFix = 2'd0;

  typedef struct packed {
    dp_op_e          op;
    div_sel_e        sel;
  } dp_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } dp_status_t;

  function automatic dp_op_e div_op(logic [KW-1:0] k);
    dp_op_e op;
    case (k)
      KDivEst: op = OP_DIV_EST;
      KDivRem: op = OP_DIV_REM;
      default: op = OP_DIV_FIX;
    endcase
    return op;
  endfunction

  function automatic logic [CountW-1:0] div_value(div_sel_e sel);
    logic [CountW-1:0] v;
    case (sel)
      DIV_DAY:  v = 32'd86400;
      DIV_HOUR: v = 32'd3600;
      DIV_MIN:  v = 32'd60;
      DIV_WEEK: v = 32'd7;
      default:  v = 32'd7;
    endcase
    return v;
  endfunction

  // floor(2^32 / divisor); the estimate is low by at most one
  function automatic logic [CountW-1:0] div_recip(div_sel_e sel);
    logic [CountW-1:0] v;
    case (sel)
      DIV_DAY:  v = 32'd49710;
      DIV_HOUR: v = 32'd1193046;
      DIV_MIN:  v = 32'd71582788;
      DIV_WEEK: v = 32'd613566756;
      default:  v = 32'd613566756;
    endcase
    return v;
  endfunction

  // years reachable from a 32-bit count span 2000..2136; 2100 is the only
  // century year in that span that is not a leap year
  function automatic logic is_leap(logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] n;
    case (mon)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: design/srcc_ctrl.sv
// controller state machine of the rtc: sequences tick, set and the read decode
// depends on srcc_pkg; drives srcc_datapath through dp_cmd_t and reads dp_status_t
module srcc_ctrl
  import srcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_LD_HOUR,
    S_DIV_HOUR,
    S_LD_MIN,
    S_DIV_MIN,
    S_LD_WDAY,
    S_DIV_WDAY,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [KW-1:0] k_q, k_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    cmd_o.op  = OP_NOP;
    cmd_o.sel = DIV_DAY;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            REQ_TICK: cmd_o.op = OP_TICK;
            REQ_SET:  cmd_o.op = OP_SET;
            REQ_READ: begin
              cmd_o.op = OP_LOAD_DAY;
              k_d      = KDivEst;
              state_d  = S_DIV_DAY;
            end
            default:  cmd_o.op = OP_NOP;
          endcase
        end
      end
      S_DIV_DAY: begin
        cmd_o.op  = div_op(k_q);
        cmd_o.sel = DIV_DAY;
        k_d       = k_q - 1'b1;
        if (k_q == KDivFix) state_d = S_LD_HOUR;
      end
      S_LD_HOUR: begin
        cmd_o.op = OP_LOAD_HOUR;
        k_d      = KDivEst;
        state_d  = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        cmd_o.op  = div_op(k_q);
        cmd_o.sel = DIV_HOUR;
        k_d       = k_q - 1'b1;
        if (k_q == KDivFix) state_d = S_LD_MIN;
      end
      S_LD_MIN: begin
        cmd_o.op = OP_LOAD_MIN;
        k_d      = KDivEst;
        state_d  = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        cmd_o.op  = div_op(k_q);
        cmd_o.sel = DIV_MIN;
        k_d       = k_q - 1'b1;
        if (k_q == KDivFix) state_d = S_LD_WDAY;
      end
      S_LD_WDAY: begin
        cmd_o.op = OP_LOAD_WDAY;
        k_d      = KDivEst;
        state_d  = S_DIV_WDAY;
      end
      S_DIV_WDAY: begin
        cmd_o.op  = div_op(k_q);
        cmd_o.sel = DIV_WEEK;
        k_d       = k_q - 1'b1;
        if (k_q == KDivFix) state_d = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_done) state_d = S_MONTH;
        else cmd_o.op = OP_YEAR_STEP;
      end
      S_MONTH: begin
        if (status_i.month_done) state_d = S_FINISH;
        else cmd_o.op = OP_MONTH_STEP;
      end
      S_FINISH: begin
        // hold the finished word until the output register frees up
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

// File: design/srcc_datapath.sv
// datapath of the rtc: seconds counter, shared reciprocal divider, year and month
// walk, and the output word register; depends on srcc_pkg
module srcc_datapath
  import srcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [CountW-1:0]    set_value_i,
  output dp_status_t           status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [OutW-1:0]      out_data_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;

  logic [CountW-1:0] snap_q;
  logic [CountW-1:0] rem_q;
  logic [DaysW-1:0]  quo_q;
  logic [DaysW-1:0]  days_q;
  logic [DaysW-1:0]  total_days_q;
  logic [11:0]       year_q;
  logic [3:0]        mon_q;
  logic [4:0]        hour_q;
  logic [5:0]        min_q;
  logic [5:0]        sec_q;
  logic [OutW-1:0]   out_q;

  logic [CountW-1:0] dv;
  logic [ProdW-1:0]  est_prod;
  logic [CountW-1:0] back_prod;
  logic              fits;
  logic              leap;
  logic [8:0]        year_len;
  logic [4:0]        mon_len;

  assign dv        = div_value(cmd_i.sel);
  // every dividend times its reciprocal stays below 2^48
  assign est_prod  = ProdW'(rem_q) * ProdW'(div_recip(cmd_i.sel));
  assign back_prod = CountW'(quo_q) * dv;
  assign fits      = (rem_q >= dv);
  assign leap      = is_leap(year_q);
  assign year_len  = leap ? 9'd366 : 9'd365;
  assign mon_len   = month_len(mon_q, leap);

  assign status_o.year_done  = (days_q < DaysW'(year_len));
  assign status_o.month_done = (days_q < DaysW'(mon_len)) || (mon_q == 4'd11);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (cmd_i.op)
      OP_TICK:     count_d = count_q + 1'b1;
      OP_SET:      count_d = set_value_i;
      OP_OUT_LOAD: out_valid_d = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CountAtReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_DAY: begin
        snap_q <= count_q;
        rem_q  <= count_q;
        quo_q  <= '0;
        year_q <= FirstYear;
        mon_q  <= '0;
      end
      OP_DIV_EST: begin
        quo_q <= est_prod[CountW +: DaysW];
      end
      OP_DIV_REM: begin
        rem_q <= rem_q - back_prod;
      end
      OP_DIV_FIX: begin
        // estimate may be one short
        if (fits) begin
          rem_q <= rem_q - dv;
          quo_q <= quo_q + 1'b1;
        end
      end
      OP_LOAD_HOUR: begin
        // remainder left in rem_q is the time of day
        days_q       <= quo_q;
        total_days_q <= quo_q;
        quo_q        <= '0;
      end
      OP_LOAD_MIN: begin
        hour_q <= quo_q[4:0];
        quo_q  <= '0;
      end
      OP_LOAD_WDAY: begin
        min_q <= quo_q[5:0];
        sec_q <= rem_q[5:0];
        rem_q <= CountW'(total_days_q + WdayOffset);
        quo_q <= '0;
      end
      OP_YEAR_STEP: begin
        days_q <= days_q - DaysW'(year_len);
        year_q <= year_q + 1'b1;
      end
      OP_MONTH_STEP: begin
        days_q <= days_q - DaysW'(mon_len);
        mon_q  <= mon_q + 1'b1;
      end
      OP_OUT_LOAD: begin
        // rem_q holds the weekday after the divide by seven
        out_q <= {rem_q[2:0], year_q, mon_q + 4'd1, days_q[4:0] + 5'd1,
                  hour_q, min_q, sec_q, snap_q};
      end
      default: ;
    endcase
  end

endmodule

// File: design/seconds_rtc_calendar_convert.sv
// top level of the seconds-count rtc with calendar decode
// depends on srcc_pkg, srcc_ctrl and srcc_datapath
//
// channel  dir  tdata                          tuser
// s_axis   in   set_value[31:0]                req_type[1:0]
// m_axis   out  seconds_total..weekday, 80b    -
//
// tick and set are taken while idle and produce no word
// a read runs four reciprocal divides (estimate, remainder and correction each),
// then the year walk and the month walk, up to its result
// s_axis_tready_o stays low while a read is decoded; a finished word waits until the
// output register is free, and the input reopens once that register is loaded
// reset loads the count with 2022-11-04 16:40:00 and empties the output register
module seconds_rtc_calendar_convert
  import srcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [InTdataW-1:0]   s_axis_tdata_i,   // set_value[31:0]
  input  logic [1:0]            s_axis_tuser_i,   // req_type[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // seconds_total[31:0], second_of_minute[37:32], minute_of_hour[43:38],
  // hour_of_day[48:44], day_of_month[53:49], month_number[57:54],
  // year_number[69:58], weekday[72:70], zero[79:73]
  output logic [OutTdataW-1:0]  m_axis_tdata_o
);

  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [OutW-1:0] out_data;

  srcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srcc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .set_value_i (s_axis_tdata_i),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata_o = {(OutTdataW - OutW)'(0), out_data};

endmodule

// File: design/srcc_checker.sv
// port-level checker for seconds_rtc_calendar_convert, attached by bind
// depends on srcc_pkg
module srcc_checker
  import srcc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [InTdataW-1:0]  s_axis_tdata_i,
  input logic [1:0]           s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o
);

  logic s_word;
  assign s_word = s_axis_tvalid_i && s_axis_tready_o;

  // a read closes the input while it is decoded
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_word && (s_axis_tuser_i == REQ_READ) |=> !s_axis_tready_o)
    else $error("input still open after a read");

  // tick, set and unused codes leave the input open
  a_other_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_word && (s_axis_tuser_i != REQ_READ) |=> s_axis_tready_o)
    else $error("input closed after a non-read word");

  // decoded fields stay in their calendar ranges
  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[37:32] < 6'd60) && (m_axis_tdata_o[43:38] < 6'd60)
      && (m_axis_tdata_o[48:44] < 5'd24) && (m_axis_tdata_o[53:49] != 5'd0)
      && (m_axis_tdata_o[57:54] != 4'd0) && (m_axis_tdata_o[57:54] < 4'd13)
      && (m_axis_tdata_o[72:70] < 3'd7) && (m_axis_tdata_o[79:73] == 7'd0))
    else $error("output field out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word dropped or changed while stalled");

endmodule

bind seconds_rtc_calendar_convert srcc_checker u_srcc_checker (.*);
